// ===== sv/hpg_pkg.sv =====
package hpg_pkg;

	localparam int unsigned IDX_W = 32;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned X_W   = 33;
	localparam int unsigned Y_W   = 32;

	localparam logic [CNT_W-1:0] CNT_RESET = 32'd2;
	localparam logic [CNT_W-1:0] DEN_RESET = 32'd1;

	// One stage takes the input, one stage per index bit forms the remainder,
	// and one stage per quotient bit forms x.
	localparam int unsigned MOD_STEPS = IDX_W;
	localparam int unsigned QUO_STEPS = X_W;
	localparam int unsigned N_STAGES  = 1 + MOD_STEPS + QUO_STEPS;

endpackage

// ===== sv/hpg_in_if.sv =====
interface hpg_in_if;

	logic                        valid;
	logic                        ready;
	logic [hpg_pkg::IDX_W-1:0]   sample_index;

	modport source (output valid, output sample_index, input ready);
	modport sink (input valid, input sample_index, output ready);

endinterface

// ===== sv/hpg_out_if.sv =====
interface hpg_out_if;

	logic                      valid;
	logic                      ready;
	logic [hpg_pkg::X_W-1:0]   coord_x;
	logic [hpg_pkg::Y_W-1:0]   coord_y;
	logic                      degenerate;

	modport source (output valid, output coord_x, output coord_y, output degenerate, input ready);
	modport sink (input valid, input coord_x, input coord_y, input degenerate, output ready);

endinterface

// ===== sv/hammersley_point_generator_top.sv =====
// Two-dimensional base-2 Hammersley point generator.
// Input channel in_ch carries a 32-bit sample_index; output channel out_ch
// carries coord_x (Q1.32, (index mod point_count) / (point_count - 1),
// truncated), coord_y (bit-reversed index, Q0.32) and degenerate, which is
// set with coord_x forced to zero when point_count is below two.
// point_count is written through cfg_we / cfg_wdata; the user must write it only
// while no point is in flight, which the block itself does not enforce; it resets to two.
// The datapath is a 66-stage pipeline: an input stage, 32 restoring steps
// for the remainder and 33 restoring steps for the quotient, each step one
// 33-bit compare and subtract. One point per cycle is sustained while the
// receiver keeps out_ch.ready high.
// An output register with a skid register behind it separates the two
// sides: when the receiver stalls the skid register fills, in_ch.ready
// drops once it is full and the whole pipeline holds, losing nothing.
// Reset empties the pipeline and both output registers.
module hammersley_point_generator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	hpg_in_if.sink                      in_ch,
	hpg_out_if.source                   out_ch,
	input  logic                        cfg_we,
	input  logic [hpg_pkg::CNT_W-1:0]   cfg_wdata
);

	typedef struct packed {
		logic [hpg_pkg::CNT_W-1:0] r;
		logic [hpg_pkg::X_W-1:0]   sh;
		logic [hpg_pkg::Y_W-1:0]   y;
		logic                      flag;
	} stage_t;

	function automatic logic [hpg_pkg::Y_W-1:0] reverse_bits(
		input logic [hpg_pkg::IDX_W-1:0] v_in
	);
		logic [31:0] v;
		v = {v_in[15:0], v_in[31:16]};
		v = ((v & 32'h5555_5555) << 1) | ((v & 32'hAAAA_AAAA) >> 1);
		v = ((v & 32'h3333_3333) << 2) | ((v & 32'hCCCC_CCCC) >> 2);
		v = ((v & 32'h0F0F_0F0F) << 4) | ((v & 32'hF0F0_F0F0) >> 4);
		v = ((v & 32'h00FF_00FF) << 8) | ((v & 32'hFF00_FF00) >> 8);
		return v;
	endfunction

	// One restoring step. In the remainder phase the next index bit is shifted
	// into the partial remainder; in the quotient phase, after its first step,
	// a zero is shifted in, and the quotient bit enters sh from the right.
	function automatic stage_t div_step(
		input stage_t                    d,
		input logic [hpg_pkg::CNT_W-1:0] dvs,
		input logic                      mod_phase,
		input logic                      first
	);
		logic [hpg_pkg::CNT_W:0] cand;
		logic [hpg_pkg::CNT_W:0] diff;
		logic                    qbit;
		stage_t                  o;
		if (first) begin
			cand = {1'b0, d.r};
		end else begin
			cand = {d.r, mod_phase ? d.sh[hpg_pkg::X_W-2] : 1'b0};
		end
		qbit = (cand >= {1'b0, dvs});
		diff = cand - {1'b0, dvs};
		o = d;
		o.r = qbit ? diff[hpg_pkg::CNT_W-1:0] : cand[hpg_pkg::CNT_W-1:0];
		o.sh = {d.sh[hpg_pkg::X_W-2:0], mod_phase ? 1'b0 : qbit};
		return o;
	endfunction

	logic [hpg_pkg::CNT_W-1:0] count_q;
	logic [hpg_pkg::CNT_W-1:0] den_q;

	stage_t pipe_s [hpg_pkg::N_STAGES];
	logic   vld_s  [hpg_pkg::N_STAGES];

	logic                      out_vld_q;
	logic [hpg_pkg::X_W-1:0]   out_x_q;
	logic [hpg_pkg::Y_W-1:0]   out_y_q;
	logic                      out_deg_q;
	logic                      skid_vld_q;
	logic [hpg_pkg::X_W-1:0]   skid_x_q;
	logic [hpg_pkg::Y_W-1:0]   skid_y_q;
	logic                      skid_deg_q;

	logic                      advance;
	logic                      push;
	logic                      pop;
	stage_t                    last;
	logic [hpg_pkg::X_W-1:0]   last_x;

	assign advance = !skid_vld_q;
	assign last    = pipe_s[hpg_pkg::N_STAGES-1];
	assign push    = vld_s[hpg_pkg::N_STAGES-1] && advance;
	assign pop     = out_vld_q && out_ch.ready;
	assign last_x  = last.flag ? '0 : last.sh;

	assign in_ch.ready       = advance;
	assign out_ch.valid      = out_vld_q;
	assign out_ch.coord_x    = out_x_q;
	assign out_ch.coord_y    = out_y_q;
	assign out_ch.degenerate = out_deg_q;

	// The divisor for x is kept ready so that no stage pays for the decrement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= hpg_pkg::CNT_RESET;
			den_q   <= hpg_pkg::DEN_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
			den_q   <= cfg_wdata - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pipe_s[0].r    <= '0;
			pipe_s[0].sh   <= {1'b0, in_ch.sample_index};
			pipe_s[0].y    <= reverse_bits(in_ch.sample_index);
			pipe_s[0].flag <= (count_q < hpg_pkg::CNT_RESET);
		end
	end

	for (genvar k = 1; k < hpg_pkg::N_STAGES; k++) begin : g_stage
		localparam bit MOD_PHASE = (k <= hpg_pkg::MOD_STEPS);
		localparam bit FIRST_Q   = (k == hpg_pkg::MOD_STEPS + 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (advance) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				pipe_s[k] <= div_step(pipe_s[k-1], MOD_PHASE ? count_q : den_q,
					MOD_PHASE, FIRST_Q);
			end
		end
	end

	// A push only happens with the skid register empty, so the two never clash.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || pop) begin
				if (skid_vld_q) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= push;
				end
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_x_q   <= skid_x_q;
				out_y_q   <= skid_y_q;
				out_deg_q <= skid_deg_q;
			end else if (push) begin
				out_x_q   <= last_x;
				out_y_q   <= last.y;
				out_deg_q <= last.flag;
			end
		end else if (push) begin
			skid_x_q   <= last_x;
			skid_y_q   <= last.y;
			skid_deg_q <= last.flag;
		end
	end

endmodule

// ===== sv/hpg_checker.sv =====
module hpg_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [hpg_pkg::X_W-1:0]   coord_x,
	input logic [hpg_pkg::Y_W-1:0]   coord_y,
	input logic                      degenerate
);

	// A stalled point stays on offer unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coord_x) && $stable(coord_y)
			&& $stable(degenerate))
		else $error("stalled output point changed");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> coord_x == '0)
		else $error("degenerate point with non-zero x");

	// x never exceeds exactly one.
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coord_x[hpg_pkg::X_W-1] |-> coord_x[hpg_pkg::X_W-2:0] == '0)
		else $error("x above one");

	// The input side only backs off after the receiver has held off a point.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input not ready without an output stall");

endmodule

bind hammersley_point_generator_top hpg_checker u_hpg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.coord_x    (out_ch.coord_x),
	.coord_y    (out_ch.coord_y),
	.degenerate (out_ch.degenerate)
);
